### rtl/core/fsadm_pkg.sv
// Package for the single-precision add/sub/mul/div unit.
// Operation codes, special IEEE words and the stage word shared by all modules.
// No dependencies.
package fsadm_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic [31:0] P_ZERO = 32'h0000_0000;
  localparam logic [31:0] N_ZERO = 32'h8000_0000;
  localparam logic [31:0] P_INF  = 32'h7f80_0000;
  localparam logic [31:0] N_INF  = 32'hff80_0000;
  localparam logic [31:0] P_NAN  = 32'h7fc0_0000;
  localparam logic [31:0] N_NAN  = 32'hffc0_0000;

  // quotient width in bits, and divider stage count for 40 bits at two per stage
  localparam int unsigned QUO_W      = 40;
  localparam int unsigned DIV_STAGES = 20;

  // word carried down the pipe: value = man / 2^63 * 2^(ex - 127)
  typedef struct packed {
    logic               spec;   // result already fixed in res
    logic [31:0]        res;
    logic               is_div;
    logic               sgn;
    logic signed [11:0] ex;
    logic [63:0]        man;
    logic [24:0]        rem;    // divider partial remainder
    logic [23:0]        dvs;    // divisor
    logic [QUO_W-1:0]   quo;
  } stg_t;

endpackage

### rtl/core/fsadm_in_if.sv
// Input channel of the float unit: opcode and two operand words.
// Depends on nothing.
interface fsadm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

### rtl/core/fsadm_out_if.sv
// Output channel of the float unit: one result word.
// Depends on nothing.
interface fsadm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

### rtl/core/fsadm_front.sv
// Front end: special-case decode, operand unpack, multiply, add alignment,
// sum, divider operand shift. Two register stages. Depends on fsadm_pkg.
module fsadm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [1:0]         op_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic               valid_o,
  output fsadm_pkg::stg_t    stg_o
);

  typedef struct packed {
    logic              spec;
    logic [31:0]       res;
    fsadm_pkg::op_e    op;
    logic              sgn;
    logic [11:0]       ex;
    logic              eff_sub;
    logic [23:0]       big_sig;
    logic [23:0]       sml_sig;
    logic [7:0]        dexp;
    logic [47:0]       prod;
    logic [23:0]       sa;
    logic [23:0]       sb;
    logic [4:0]        lza;
    logic [4:0]        lzb;
  } f1_t;

  function automatic logic is_zero(logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  function automatic logic is_inf(logic [31:0] v);
    return v[30:0] == fsadm_pkg::P_INF[30:0];
  endfunction

  function automatic logic is_nan(logic [31:0] v);
    return v[30:0] > fsadm_pkg::P_INF[30:0];
  endfunction

  function automatic logic is_cnan(logic [31:0] v);
    return v == fsadm_pkg::P_NAN || v == fsadm_pkg::N_NAN;
  endfunction

  function automatic logic [32:0] add_spec(logic [31:0] x, logic [31:0] y);
    logic [32:0] r;
    r = 33'd0;
    if (x == fsadm_pkg::P_ZERO && y == fsadm_pkg::P_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::N_ZERO && y == fsadm_pkg::P_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::P_ZERO && y == fsadm_pkg::N_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::N_ZERO && y == fsadm_pkg::N_ZERO) r = {1'b1, fsadm_pkg::N_ZERO};
    else if ((x == fsadm_pkg::P_INF && y == fsadm_pkg::N_INF) ||
             (x == fsadm_pkg::N_INF && y == fsadm_pkg::P_INF)) r = {1'b1, fsadm_pkg::N_NAN};
    else if ((x == fsadm_pkg::P_INF || x == fsadm_pkg::N_INF) && y == fsadm_pkg::P_NAN)
      r = {1'b1, fsadm_pkg::P_NAN};
    else if ((x == fsadm_pkg::P_INF || x == fsadm_pkg::N_INF) && y == fsadm_pkg::N_NAN)
      r = {1'b1, fsadm_pkg::N_NAN};
    else if (x == fsadm_pkg::N_NAN && y == fsadm_pkg::P_NAN) r = {1'b1, fsadm_pkg::P_NAN};
    else if (is_zero(x)) r = {1'b1, y};
    else if (is_zero(y)) r = {1'b1, x};
    else if (x[30:23] == 8'hff) r = {1'b1, x};
    else if (y[30:23] == 8'hff) r = {1'b1, y};
    return r;
  endfunction

  function automatic logic [32:0] sub_spec(logic [31:0] x, logic [31:0] y);
    logic [32:0] r;
    r = 33'd0;
    if (x == fsadm_pkg::P_ZERO && y == fsadm_pkg::P_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::N_ZERO && y == fsadm_pkg::P_ZERO) r = {1'b1, fsadm_pkg::N_ZERO};
    else if (x == fsadm_pkg::P_ZERO && y == fsadm_pkg::N_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::N_ZERO && y == fsadm_pkg::N_ZERO) r = {1'b1, fsadm_pkg::P_ZERO};
    else if (x == fsadm_pkg::N_NAN && y == fsadm_pkg::P_NAN) r = {1'b1, fsadm_pkg::P_NAN};
    else if (x == fsadm_pkg::P_NAN && y == fsadm_pkg::N_NAN) r = {1'b1, fsadm_pkg::P_NAN};
    else if (is_cnan(x)) r = {1'b1, x};
    else if (is_cnan(y)) r = {1'b1, y};
    else r = add_spec(x, y ^ fsadm_pkg::N_ZERO);
    return r;
  endfunction

  function automatic logic [32:0] nan_pick(logic [31:0] x, logic [31:0] y);
    logic [32:0] r;
    r = 33'd0;
    if (is_cnan(x) || is_cnan(y))
      r = {1'b1, (x == fsadm_pkg::P_NAN || y == fsadm_pkg::P_NAN) ?
                 fsadm_pkg::P_NAN : fsadm_pkg::N_NAN};
    else if (is_nan(x)) r = {1'b1, x};
    else if (is_nan(y)) r = {1'b1, y};
    return r;
  endfunction

  function automatic logic [32:0] mul_spec(logic [31:0] x, logic [31:0] y);
    logic [32:0] r;
    logic        s;
    s = x[31] ^ y[31];
    if ((is_zero(x) && is_inf(y)) || (is_inf(x) && is_zero(y))) r = {1'b1, fsadm_pkg::N_NAN};
    else begin
      r = nan_pick(x, y);
      if (!r[32]) begin
        if (is_zero(x) || is_zero(y)) r = {1'b1, s, 31'd0};
        else if (is_inf(x) || is_inf(y)) r = {1'b1, s, fsadm_pkg::P_INF[30:0]};
      end
    end
    return r;
  endfunction

  function automatic logic [32:0] div_spec(logic [31:0] x, logic [31:0] y);
    logic [32:0] r;
    logic        s;
    s = x[31] ^ y[31];
    if (is_zero(x) && is_zero(y)) r = {1'b1, fsadm_pkg::N_NAN};
    else if (is_inf(x) && is_zero(y)) r = {1'b1, s, fsadm_pkg::P_INF[30:0]};
    else if (is_inf(x) && is_inf(y)) r = {1'b1, fsadm_pkg::N_NAN};
    else begin
      r = nan_pick(x, y);
      if (!r[32]) begin
        if (is_inf(x) || is_zero(y)) r = {1'b1, s, fsadm_pkg::P_INF[30:0]};
        else if (is_zero(x) || is_inf(y)) r = {1'b1, s, 31'd0};
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] lz24(logic [23:0] v);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  function automatic logic [23:0] sig(logic [31:0] v);
    return {v[30:23] != 8'd0, v[22:0]};
  endfunction

  function automatic logic [7:0] xexp(logic [31:0] v);
    return (v[30:23] != 8'd0) ? v[30:23] : 8'd1;
  endfunction

  // ---- stage 1
  f1_t         f1_d, f1_q;
  logic        f1_vld_q;
  logic [31:0] bb, big, sml;
  logic [32:0] spec;
  logic [4:0]  lza, lzb;

  always_comb begin
    fsadm_pkg::op_e op;
    op   = fsadm_pkg::op_e'(op_i);
    bb   = (op == fsadm_pkg::OP_SUB) ? (b_i ^ fsadm_pkg::N_ZERO) : b_i;
    if (a_i[30:0] >= bb[30:0]) begin
      big = a_i;
      sml = bb;
    end else begin
      big = bb;
      sml = a_i;
    end
    lza = lz24(sig(a_i));
    lzb = lz24(sig(b_i));
    case (op)
      fsadm_pkg::OP_ADD: spec = add_spec(a_i, b_i);
      fsadm_pkg::OP_SUB: spec = sub_spec(a_i, b_i);
      fsadm_pkg::OP_MUL: spec = mul_spec(a_i, b_i);
      default:           spec = div_spec(a_i, b_i);
    endcase

    f1_d         = '0;
    f1_d.spec    = spec[32];
    f1_d.res     = spec[31:0];
    f1_d.op      = op;
    f1_d.eff_sub = big[31] ^ sml[31];
    f1_d.big_sig = sig(big);
    f1_d.sml_sig = sig(sml);
    f1_d.dexp    = xexp(big) - xexp(sml);
    f1_d.prod    = sig(a_i) * sig(b_i);
    f1_d.sa      = sig(a_i);
    f1_d.sb      = sig(b_i);
    f1_d.lza     = lza;
    f1_d.lzb     = lzb;
    case (op)
      fsadm_pkg::OP_ADD, fsadm_pkg::OP_SUB: begin
        f1_d.sgn = big[31];
        f1_d.ex  = {4'd0, xexp(big)} + 12'd1;
      end
      fsadm_pkg::OP_MUL: begin
        f1_d.sgn = a_i[31] ^ b_i[31];
        f1_d.ex  = {4'd0, xexp(a_i)} + {4'd0, xexp(b_i)} - 12'd110;
      end
      default: begin
        f1_d.sgn = a_i[31] ^ b_i[31];
        f1_d.ex  = {4'd0, xexp(a_i)} - {7'd0, lza} - {4'd0, xexp(b_i)}
                   + {7'd0, lzb} + 12'd151;
      end
    endcase
  end

  // ---- stage 2
  fsadm_pkg::stg_t f2_d, f2_q;
  logic            f2_vld_q;
  logic [63:0]     mbig, msml, mshf, sum;
  logic [5:0]      sh6;
  logic [23:0]     na, nb;

  always_comb begin
    mbig = {1'b0, f1_q.big_sig, 39'd0};
    msml = {1'b0, f1_q.sml_sig, 39'd0};
    sh6  = f1_q.dexp[5:0];
    if (f1_q.dexp >= 8'd63) mshf = 64'd1;
    else mshf = (msml >> sh6) | {63'd0, (msml & ((64'd1 << sh6) - 64'd1)) != 64'd0};
    sum  = f1_q.eff_sub ? (mbig - mshf) : (mbig + mshf);
    na   = f1_q.sa << f1_q.lza;
    nb   = f1_q.sb << f1_q.lzb;

    f2_d        = '0;
    f2_d.spec   = f1_q.spec;
    f2_d.res    = f1_q.res;
    f2_d.sgn    = f1_q.sgn;
    f2_d.ex     = $signed(f1_q.ex);
    f2_d.rem    = {1'b0, na};
    f2_d.dvs    = nb;
    case (f1_q.op)
      fsadm_pkg::OP_ADD, fsadm_pkg::OP_SUB: begin
        f2_d.man = sum;
        // exact cancellation gives +0
        if (sum == 64'd0) f2_d.sgn = 1'b0;
      end
      fsadm_pkg::OP_MUL: f2_d.man = {16'd0, f1_q.prod};
      default:           f2_d.is_div = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en_i) begin
      f1_vld_q <= valid_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
    end
  end

  assign valid_o = f2_vld_q;
  assign stg_o   = f2_q;

endmodule

### rtl/core/fsadm_div.sv
// Pipelined restoring divider, two quotient bits per stage.
// Other operations ride through untouched. Depends on fsadm_pkg.
module fsadm_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fsadm_pkg::stg_t stg_i,
  output logic            valid_o,
  output fsadm_pkg::stg_t stg_o
);

  localparam int unsigned N = fsadm_pkg::DIV_STAGES;

  function automatic fsadm_pkg::stg_t div_step(fsadm_pkg::stg_t x);
    fsadm_pkg::stg_t y;
    logic            qb;
    y  = x;
    qb = x.rem >= {1'b0, x.dvs};
    if (qb) y.rem = x.rem - {1'b0, x.dvs};
    y.rem = {y.rem[23:0], 1'b0};
    y.quo = {x.quo[fsadm_pkg::QUO_W-2:0], qb};
    return y;
  endfunction

  fsadm_pkg::stg_t pipe_q [N];
  fsadm_pkg::stg_t pipe_d [N];
  logic [N-1:0]    vld_q;

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        pipe_d[k] = div_step(div_step(stg_i));
      end
    end else begin : g_rest
      always_comb begin
        pipe_d[k] = div_step(div_step(pipe_q[k-1]));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) pipe_q[k] <= pipe_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  // quotient with sticky from the remainder
  always_comb begin
    stg_o = pipe_q[N-1];
    if (pipe_q[N-1].is_div)
      stg_o.man = {24'd0, pipe_q[N-1].quo} | {63'd0, pipe_q[N-1].rem != 25'd0};
  end

  assign valid_o = vld_q[N-1];

endmodule

### rtl/core/fsadm_round.sv
// Normalise, denormalise and round-to-nearest-even, then pack the result word.
// Four register stages. Depends on fsadm_pkg.
module fsadm_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fsadm_pkg::stg_t stg_i,
  output logic            valid_o,
  output logic [31:0]     res_o
);

  typedef struct packed {
    logic               spec;
    logic [31:0]        res;
    logic               sgn;
    logic signed [11:0] ex;
    logic [63:0]        man;
  } nrm_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] res;
    logic        sgn;
    logic [7:0]  e8;
    logic [63:0] man;
  } dnm_t;

  nrm_t        n1_d, n1_q, n2_d, n2_q;
  dnm_t        dn_d, dn_q;
  logic [31:0] res_d, res_q;
  logic [3:0]  vld_q;

  // byte-wise leading zero shift
  always_comb begin
    logic [2:0] lzb;
    lzb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (stg_i.man[8*i +: 8] != 8'd0) lzb = 3'(7 - i);
    end
    n1_d.spec = stg_i.spec;
    n1_d.res  = stg_i.res;
    n1_d.sgn  = stg_i.sgn;
    n1_d.man  = stg_i.man << {lzb, 3'b000};
    n1_d.ex   = stg_i.ex - $signed({6'd0, lzb, 3'b000});
    if (!stg_i.spec && stg_i.man == 64'd0) begin
      n1_d.spec = 1'b1;
      n1_d.res  = {stg_i.sgn, 31'd0};
    end
  end

  // bit-wise within the top byte
  always_comb begin
    logic [2:0] lz;
    lz = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (n1_q.man[56 + i]) lz = 3'(7 - i);
    end
    n2_d     = n1_q;
    n2_d.man = n1_q.man << lz;
    n2_d.ex  = n1_q.ex - $signed({9'd0, lz});
  end

  // overflow check and shift into the denormal range
  always_comb begin
    logic [11:0] sh;
    logic [5:0]  sh6;
    sh       = 12'd1 - n2_q.ex;
    sh6      = sh[5:0];
    dn_d.spec = n2_q.spec;
    dn_d.res  = n2_q.res;
    dn_d.sgn  = n2_q.sgn;
    dn_d.man  = n2_q.man;
    dn_d.e8   = n2_q.ex[7:0];
    if (n2_q.ex >= 12'sd255) begin
      if (!n2_q.spec) begin
        dn_d.spec = 1'b1;
        dn_d.res  = {n2_q.sgn, fsadm_pkg::P_INF[30:0]};
      end
    end else if (n2_q.ex <= 12'sd0) begin
      dn_d.e8 = 8'd0;
      if (sh >= 12'd64) dn_d.man = 64'd1;
      else dn_d.man = (n2_q.man >> sh6) |
                      {63'd0, (n2_q.man << (7'd64 - {1'b0, sh6})) != 64'd0};
    end
  end

  // round and pack
  always_comb begin
    logic [24:0] keep;
    logic        inc;
    logic [7:0]  e;
    inc  = dn_q.man[39] && ((dn_q.man[38:0] != 39'd0) || dn_q.man[40]);
    keep = {1'b0, dn_q.man[63:40]} + {24'd0, inc};
    e    = dn_q.e8;
    if (dn_q.spec) begin
      res_d = dn_q.res;
    end else if (e == 8'd0) begin
      res_d = {dn_q.sgn, 7'd0, keep[23], keep[22:0]};
    end else if (keep[24]) begin
      if (e == 8'd254) res_d = {dn_q.sgn, fsadm_pkg::P_INF[30:0]};
      else res_d = {dn_q.sgn, e + 8'd1, keep[23:1]};
    end else begin
      res_d = {dn_q.sgn, e, keep[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q  <= n1_d;
      n2_q  <= n2_d;
      dn_q  <= dn_d;
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[3];
  assign res_o   = res_q;

endmodule

### rtl/core/single_float_add_sub_mul_div_top.sv
// Single-precision add / subtract / multiply / divide unit, top level.
// Uses fsadm_pkg, fsadm_in_if, fsadm_out_if, fsadm_front, fsadm_div, fsadm_round.
//
// in_i carries an opcode (add, subtract, multiply, divide) and two operand
// words; out_o returns one rounded result word per accepted input word, in
// order. Both use valid/ready; a word moves when both are high.
// Every operation passes the same chain: 2 front stages (special cases,
// multiply, alignment and add), 20 divider stages of two quotient bits each,
// and 4 stages of normalise, denormal shift and round.
// Throughput is one word per cycle while out_o does not stall: the divider array
// is fully pipelined and every operation flows through the same stage chain.
// Reset empties the pipe; nothing else is held.
// When the receiver stalls with a result waiting, the whole pipe freezes and
// in_i.ready falls; no word is lost or repeated. Bubbles fill in while the
// output is empty.
module single_float_add_sub_mul_div_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsadm_in_if.sink    in_i,
  fsadm_out_if.source out_o
);

  logic            en;
  logic            fr_vld, dv_vld, rd_vld;
  fsadm_pkg::stg_t fr_stg, dv_stg;
  logic [31:0]     rd_res;

  assign en = !rd_vld || out_o.ready;

  fsadm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .op_i    (in_i.op),
    .a_i     (in_i.operand_a),
    .b_i     (in_i.operand_b),
    .valid_o (fr_vld),
    .stg_o   (fr_stg)
  );

  fsadm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .stg_i   (fr_stg),
    .valid_o (dv_vld),
    .stg_o   (dv_stg)
  );

  fsadm_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .stg_i   (dv_stg),
    .valid_o (rd_vld),
    .res_o   (rd_res)
  );

  assign in_i.ready   = en;
  assign out_o.valid  = rd_vld;
  assign out_o.result = rd_res;

endmodule
